// ===== hw/rtl/pbpe_pkg.sv =====
// package: constants, codes and shared types of the planar bitmap pixel engine
`timescale 1ns / 1ps
package pbpe_pkg;

	// default sizes
	localparam int MAX_PLANES_D    = 8;
	localparam int PLANE_BYTES_D   = 65536;
	localparam int MAX_ROW_BYTES_D = 256;

	// field widths
	localparam int ACT_W   = 2;
	localparam int X_W     = 11;
	localparam int Y_W     = 16;
	localparam int PIX_W   = 8;
	localparam int BPR_W   = 9;
	localparam int ROWS_W  = 17;
	localparam int PCNT_W  = 4;
	localparam int MODES_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;
	localparam int PROD_W  = Y_W + BPR_W;
	localparam int OFF_W   = PROD_W + 1;

	// action codes
	localparam logic [ACT_W-1:0] ACT_PUT    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_GET    = 2'd1;
	localparam logic [ACT_W-1:0] ACT_EXPAND = 2'd2;

	// plane mode codes
	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_ABSENT = 2'd1;
	localparam logic [1:0] MODE_ONES   = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_ROW = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_MODES   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OPAQUE_MODE   = 3'd6;

	// register reset values
	localparam logic [BPR_W-1:0]   BPR_RST    = 9'd40;
	localparam logic [ROWS_W-1:0]  ROWS_RST   = 17'd256;
	localparam logic [PCNT_W-1:0]  PCNT_RST   = 4'd8;
	localparam logic [MODES_W-1:0] MODES_RST  = 16'd0;
	localparam logic [PIX_W-1:0]   FG_RST     = 8'd1;
	localparam logic [PIX_W-1:0]   BG_RST     = 8'd0;

	// bit of the first pixel in a byte
	localparam logic [7:0] LEFT_BIT = 8'h80;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_OFFS,
		ST_READ,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clearing;
		logic in_ready;
		logic load;
		logic mul;
		logic offs;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic clear_last;
		logic out_free;
	} status_t;

endpackage

// ===== hw/rtl/pbpe_if.sv =====
// interfaces: pixel request channel and result channel
`timescale 1ns / 1ps
interface pbpe_in_if;
	logic                         valid;
	logic                         ready;
	logic [pbpe_pkg::ACT_W-1:0]   action;
	logic [pbpe_pkg::X_W-1:0]     x_coord;
	logic [pbpe_pkg::Y_W-1:0]     y_coord;
	logic [pbpe_pkg::PIX_W-1:0]   pixel_value;
	logic                         mask_bit;

	modport source (output valid, action, x_coord, y_coord, pixel_value, mask_bit,
		input ready);
	modport sink (input valid, action, x_coord, y_coord, pixel_value, mask_bit,
		output ready);
endinterface

interface pbpe_out_if;
	logic                         valid;
	logic                         ready;
	logic [pbpe_pkg::PIX_W-1:0]   read_value;
	logic                         out_of_range;

	modport source (output valid, read_value, out_of_range, input ready);
	modport sink (input valid, read_value, out_of_range, output ready);
endinterface

// ===== hw/rtl/planar_bitmap_pixel_engine.sv =====
// top level: planar bitmap pixel engine
`timescale 1ns / 1ps
// Holds a bitmap as up to MAX_PLANES bit planes of PLANE_BYTES bytes each. A word on
// in_ch puts a pixel, gets a pixel or does a colour-expand write at (x_coord, y_coord);
// each word gives exactly one result word on out_ch. After reset the block sweeps
// all planes to zero, one byte address of every plane per cycle, and takes no word
// until the sweep is done; config writes are taken at any time. Each word then takes
// five steps: accept, y times bytes per row on the one multiplier, offset add and
// range check, a registered read of the plane memories, and the read-modify-write of
// the addressed byte together with loading the result register, which waits until
// that register has room. No word is taken before the last one's write-back; the
// next word is accepted while a result still waits in the output register.
module planar_bitmap_pixel_engine #(
	parameter int MAX_PLANES    = pbpe_pkg::MAX_PLANES_D,
	parameter int PLANE_BYTES   = pbpe_pkg::PLANE_BYTES_D,
	parameter int MAX_ROW_BYTES = pbpe_pkg::MAX_ROW_BYTES_D
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [pbpe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pbpe_pkg::CFG_DATA_W-1:0] cfg_data,
	pbpe_in_if.sink                         in_ch,
	pbpe_out_if.source                      out_ch
);

	pbpe_pkg::cmd_t    cmd;
	pbpe_pkg::status_t status_dp;
	pbpe_pkg::status_t status;
	pbpe_pkg::state_t  state;

	// input valid joins the datapath status toward the controller
	always_comb begin
		status          = status_dp;
		status.in_valid = in_ch.valid;
	end

	pbpe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd),
		.state  (state)
	);

	pbpe_dp #(
		.MAX_PLANES    (MAX_PLANES),
		.PLANE_BYTES   (PLANE_BYTES),
		.MAX_ROW_BYTES (MAX_ROW_BYTES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_action      (in_ch.action),
		.in_x           (in_ch.x_coord),
		.in_y           (in_ch.y_coord),
		.in_pixel       (in_ch.pixel_value),
		.in_mask        (in_ch.mask_bit),
		.cmd            (cmd),
		.status_dp      (status_dp),
		.out_ready      (out_ch.ready),
		.out_valid      (out_ch.valid),
		.out_read_value (out_ch.read_value),
		.out_oor        (out_ch.out_of_range)
	);

	// ready only while idle, never during the clearing sweep
	assign in_ch.ready = cmd.in_ready;

	// an accepted word reaches the write-back step after the multiply, offset and read steps
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |-> ##4 (state == pbpe_pkg::ST_DONE))
		else $error("accepted word did not reach write-back on time");

	// a new result only appears right after the write-back step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> $past(state == pbpe_pkg::ST_DONE))
		else $error("result word appeared without write-back");

	// no word is taken while the planes are being cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		(state == pbpe_pkg::ST_CLEAR) |-> !in_ch.ready)
		else $error("word accepted during clearing sweep");

	// write-back never overruns an undelivered result
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_ch.valid || out_ch.ready))
		else $error("result register overwritten");

endmodule

// ===== hw/rtl/pbpe_ctrl.sv =====
// controller: sequences clearing and the steps of one pixel word
`timescale 1ns / 1ps
module pbpe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  pbpe_pkg::status_t status,
	output pbpe_pkg::cmd_t    cmd,
	output pbpe_pkg::state_t  state
);

	pbpe_pkg::state_t state_q;
	pbpe_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pbpe_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			pbpe_pkg::ST_CLEAR: begin
				cmd.clearing = 1'b1;
				if (status.clear_last) begin
					state_nxt = pbpe_pkg::ST_IDLE;
				end
			end
			pbpe_pkg::ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (status.in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = pbpe_pkg::ST_MUL;
				end
			end
			pbpe_pkg::ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = pbpe_pkg::ST_OFFS;
			end
			pbpe_pkg::ST_OFFS: begin
				cmd.offs  = 1'b1;
				state_nxt = pbpe_pkg::ST_READ;
			end
			pbpe_pkg::ST_READ: begin
				state_nxt = pbpe_pkg::ST_DONE;
			end
			pbpe_pkg::ST_DONE: begin
				// hold until the result register has room
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_nxt  = pbpe_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = pbpe_pkg::ST_IDLE;
			end
		endcase
	end

	assign state = state_q;

endmodule

// ===== hw/rtl/pbpe_dp.sv =====
// datapath: config registers, address math, plane memories and result register
`timescale 1ns / 1ps
module pbpe_dp #(
	parameter int MAX_PLANES    = pbpe_pkg::MAX_PLANES_D,
	parameter int PLANE_BYTES   = pbpe_pkg::PLANE_BYTES_D,
	parameter int MAX_ROW_BYTES = pbpe_pkg::MAX_ROW_BYTES_D
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [pbpe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pbpe_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [pbpe_pkg::ACT_W-1:0]        in_action,
	input  logic [pbpe_pkg::X_W-1:0]          in_x,
	input  logic [pbpe_pkg::Y_W-1:0]          in_y,
	input  logic [pbpe_pkg::PIX_W-1:0]        in_pixel,
	input  logic                              in_mask,
	input  pbpe_pkg::cmd_t                    cmd,
	output pbpe_pkg::status_t                 status_dp,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [pbpe_pkg::PIX_W-1:0]        out_read_value,
	output logic                              out_oor
);

	localparam int AW = (PLANE_BYTES > 1) ? $clog2(PLANE_BYTES) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(PLANE_BYTES - 1);

	// configuration
	logic [pbpe_pkg::BPR_W-1:0]   bpr_q;
	logic [pbpe_pkg::ROWS_W-1:0]  rows_q;
	logic [pbpe_pkg::PCNT_W-1:0]  pcnt_q;
	logic [pbpe_pkg::MODES_W-1:0] modes_q;
	logic [pbpe_pkg::PIX_W-1:0]   fg_q;
	logic [pbpe_pkg::PIX_W-1:0]   bg_q;
	logic                         opaque_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpr_q    <= pbpe_pkg::BPR_RST;
			rows_q   <= pbpe_pkg::ROWS_RST;
			pcnt_q   <= pbpe_pkg::PCNT_RST;
			modes_q  <= pbpe_pkg::MODES_RST;
			fg_q     <= pbpe_pkg::FG_RST;
			bg_q     <= pbpe_pkg::BG_RST;
			opaque_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				pbpe_pkg::REG_BYTES_PER_ROW: bpr_q    <= cfg_data[pbpe_pkg::BPR_W-1:0];
				pbpe_pkg::REG_ROW_COUNT:     rows_q   <= cfg_data[pbpe_pkg::ROWS_W-1:0];
				pbpe_pkg::REG_PLANE_COUNT:   pcnt_q   <= cfg_data[pbpe_pkg::PCNT_W-1:0];
				pbpe_pkg::REG_PLANE_MODES:   modes_q  <= cfg_data[pbpe_pkg::MODES_W-1:0];
				pbpe_pkg::REG_FG_COLOR:      fg_q     <= cfg_data[pbpe_pkg::PIX_W-1:0];
				pbpe_pkg::REG_BG_COLOR:      bg_q     <= cfg_data[pbpe_pkg::PIX_W-1:0];
				pbpe_pkg::REG_OPAQUE_MODE:   opaque_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// saturated sizes
	logic [pbpe_pkg::BPR_W-1:0]  bpr_sat;
	logic [pbpe_pkg::PCNT_W-1:0] depth;

	assign bpr_sat = ({2'b00, bpr_q} > 11'(MAX_ROW_BYTES)) ?
		pbpe_pkg::BPR_W'(MAX_ROW_BYTES) : bpr_q;
	assign depth = (pcnt_q > pbpe_pkg::PCNT_W'(MAX_PLANES)) ?
		pbpe_pkg::PCNT_W'(MAX_PLANES) : pcnt_q;

	// item registers
	logic [pbpe_pkg::ACT_W-1:0] act_q;
	logic [pbpe_pkg::X_W-1:0]   x_q;
	logic [pbpe_pkg::Y_W-1:0]   y_q;
	logic [pbpe_pkg::PIX_W-1:0] pix_q;
	logic                       mask_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= in_action;
			x_q    <= in_x;
			y_q    <= in_y;
			pix_q  <= in_pixel;
			mask_q <= in_mask;
		end
	end

	// address: multiply, then add and range check
	logic [pbpe_pkg::PROD_W-1:0] prod_q;
	logic                        x_oob_q;
	logic                        y_oob_q;
	logic [pbpe_pkg::OFF_W-1:0]  off_sum;
	logic [pbpe_pkg::OFF_W-1:0]  off_q;
	logic                        oob_q;

	assign off_sum = {1'b0, prod_q} + pbpe_pkg::OFF_W'(x_q[pbpe_pkg::X_W-1:3]);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q  <= pbpe_pkg::PROD_W'(y_q) * pbpe_pkg::PROD_W'(bpr_sat);
			x_oob_q <= {1'b0, x_q} >= {bpr_sat, 3'b000};
			y_oob_q <= {1'b0, y_q} >= rows_q;
		end
		if (cmd.offs) begin
			off_q <= off_sum;
			oob_q <= x_oob_q || y_oob_q || (off_sum >= pbpe_pkg::OFF_W'(PLANE_BYTES));
		end
	end

	// clearing sweep
	logic [AW-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clearing) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// plane memories
	logic [AW-1:0] mem_addr;
	logic [7:0]    bit_sel;
	logic          pen_write;

	assign mem_addr  = cmd.clearing ? clr_q : off_q[AW-1:0];
	assign bit_sel   = pbpe_pkg::LEFT_BIT >> x_q[2:0];
	assign pen_write = !oob_q && ((act_q == pbpe_pkg::ACT_PUT) ||
		((act_q == pbpe_pkg::ACT_EXPAND) && (mask_q || opaque_q)));

	logic [MAX_PLANES-1:0] plane_bit;

	for (genvar d = 0; d < MAX_PLANES; d++) begin : g_plane
		logic [7:0] mem [PLANE_BYTES];
		logic [7:0] rd_q;
		logic [1:0] mode;
		logic       active;
		logic       pen;
		logic       we;
		logic [7:0] wdata;

		assign mode   = modes_q[2*d +: 2];
		assign active = pbpe_pkg::PCNT_W'(d) < depth;
		assign pen    = (act_q == pbpe_pkg::ACT_PUT) ? pix_q[d] :
			(mask_q ? fg_q[d] : bg_q[d]);
		assign we     = cmd.clearing ||
			(cmd.finish && pen_write && active && (mode == pbpe_pkg::MODE_NORMAL));
		assign wdata  = cmd.clearing ? 8'h00 : (pen ? (rd_q | bit_sel) : (rd_q & ~bit_sel));

		always_ff @(posedge clk) begin
			if (we) begin
				mem[mem_addr] <= wdata;
			end
			rd_q <= mem[mem_addr];
		end

		assign plane_bit[d] = active && ((mode == pbpe_pkg::MODE_ONES) ||
			((mode == pbpe_pkg::MODE_NORMAL) && ((rd_q & bit_sel) != 8'h00)));
	end

	// result
	logic [pbpe_pkg::PIX_W-1:0] rv_next;
	logic                       is_get;
	logic                       is_noop;

	assign is_get  = act_q == pbpe_pkg::ACT_GET;
	assign is_noop = !(is_get || (act_q == pbpe_pkg::ACT_PUT) ||
		(act_q == pbpe_pkg::ACT_EXPAND));
	assign rv_next = (is_get && !oob_q) ? pbpe_pkg::PIX_W'(plane_bit) : '0;

	logic                       ovalid_q;
	logic [pbpe_pkg::PIX_W-1:0] orv_q;
	logic                       ooor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.finish) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			orv_q  <= rv_next;
			ooor_q <= oob_q && !is_noop;
		end
	end

	assign out_valid      = ovalid_q;
	assign out_read_value = orv_q;
	assign out_oor        = ooor_q;

	assign status_dp.in_valid   = 1'b0;
	assign status_dp.clear_last = clr_q == LAST_ADDR;
	assign status_dp.out_free   = !ovalid_q || out_ready;

endmodule
